// ----- design/jet_pkg.sv -----
// ----------------------------------------------------------------------------
// jet_pkg
// Shared constants, register map, state encoding and control bundles for the
// Julia-set escape-time engine.
// ----------------------------------------------------------------------------
package jet_pkg;

	localparam int COORD_BITS_DEF = 14;
	localparam int FRAC_BITS_DEF  = 20;

	localparam int C_BITS     = 22;
	localparam int ITER_BITS  = 12;
	localparam int LIMIT_BITS = 11;
	localparam int STEP_BITS  = 20;
	localparam int MAG_BITS   = 44;

	localparam int CFG_ADDR_BITS = 5;
	localparam int REG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [REG_IDX_BITS-1:0] REG_C_REAL   = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_C_IMAG   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_MAX_ITER = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_LIMIT    = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_STEP     = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_CENTER   = 3'd5;

	localparam logic signed [C_BITS-1:0] C_REAL_RST   = -22'sd762209;
	localparam logic signed [C_BITS-1:0] C_IMAG_RST   = 22'sd198077;
	localparam logic [ITER_BITS-1:0]     MAX_ITER_RST = 12'd300;
	localparam logic [LIMIT_BITS-1:0]    LIMIT_RST    = 11'd1000;
	localparam logic [STEP_BITS-1:0]     STEP_RST     = 20'd256;
	localparam int                       CENTER_RST   = 6144;

	localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIFF,
		ST_STEP,
		ST_FINISH
	} jet_state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic out_load;
		logic out_esc;
	} jet_cmd_t;

	typedef struct packed {
		logic pass_zero;
		logic pass_last;
		logic mag_gt;
	} jet_status_t;

endpackage

// ----- design/jet_regs.sv -----
// ----------------------------------------------------------------------------
// jet_regs
// APB-style register file holding the Julia constant, iteration limit,
// escape bound and pixel mapping.
// ----------------------------------------------------------------------------
module jet_regs import jet_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [CFG_ADDR_BITS-1:0]     paddr,
	input  logic [CFG_DATA_BITS-1:0]     pwdata,
	output logic [CFG_DATA_BITS-1:0]     prdata,
	output logic                         pready,
	output logic signed [C_BITS-1:0]     c_real,
	output logic signed [C_BITS-1:0]     c_imag,
	output logic [ITER_BITS-1:0]         max_iterations,
	output logic [LIMIT_BITS-1:0]        escape_limit,
	output logic [STEP_BITS-1:0]         pixel_step,
	output logic [COORD_BITS-1:0]        center_offset
);

	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    wr_en;

	assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real         <= C_REAL_RST;
			c_imag         <= C_IMAG_RST;
			max_iterations <= MAX_ITER_RST;
			escape_limit   <= LIMIT_RST;
			pixel_step     <= STEP_RST;
			center_offset  <= COORD_BITS'(CENTER_RST);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_C_REAL:   c_real         <= $signed(pwdata[C_BITS-1:0]);
				REG_C_IMAG:   c_imag         <= $signed(pwdata[C_BITS-1:0]);
				REG_MAX_ITER: max_iterations <= pwdata[ITER_BITS-1:0];
				REG_LIMIT:    escape_limit   <= pwdata[LIMIT_BITS-1:0];
				REG_STEP:     pixel_step     <= pwdata[STEP_BITS-1:0];
				REG_CENTER:   center_offset  <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_C_REAL:   prdata = CFG_DATA_BITS'(c_real);
			REG_C_IMAG:   prdata = CFG_DATA_BITS'(c_imag);
			REG_MAX_ITER: prdata = CFG_DATA_BITS'(max_iterations);
			REG_LIMIT:    prdata = CFG_DATA_BITS'(escape_limit);
			REG_STEP:     prdata = CFG_DATA_BITS'(pixel_step);
			REG_CENTER:   prdata = CFG_DATA_BITS'(center_offset);
			default:      prdata = '0;
		endcase
	end

endmodule

// ----- design/jet_ctrl.sv -----
// ----------------------------------------------------------------------------
// jet_ctrl
// Sequencer for one pixel: four-state iteration loop, escape decision and
// output register handshake.
// ----------------------------------------------------------------------------
module jet_ctrl import jet_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  jet_status_t st,
	output jet_cmd_t    cmd
);

	jet_state_t state_q, state_d;
	logic       esc_q, esc_d;
	logic       out_valid_d;
	logic       escape_now;
	logic       slot_free;

	assign escape_now = st.mag_gt && !st.pass_zero;
	assign slot_free  = !out_valid || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		esc_d   = esc_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MUL;
			ST_MUL:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_STEP;
			ST_STEP: begin
				esc_d = escape_now;
				if (escape_now || st.pass_last) state_d = ST_FINISH;
				else state_d = ST_MUL;
			end
			ST_FINISH: if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.update   = (state_q == ST_STEP) && !escape_now && !st.pass_last;
		cmd.out_load = (state_q == ST_FINISH) && slot_free;
		cmd.out_esc  = esc_q;
		out_valid_d  = cmd.out_load || (out_valid && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			esc_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			esc_q     <= esc_d;
			out_valid <= out_valid_d;
		end
	end

endmodule

// ----- design/jet_datapath.sv -----
// ----------------------------------------------------------------------------
// jet_datapath
// Start-point mapping, split squarer and cross multiplier, magnitude test,
// z update with floor rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module jet_datapath import jet_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  jet_cmd_t                     cmd,
	output jet_status_t                  st,
	input  logic [COORD_BITS-1:0]        pixel_x,
	input  logic [COORD_BITS-1:0]        pixel_y,
	input  logic signed [C_BITS-1:0]     c_real,
	input  logic signed [C_BITS-1:0]     c_imag,
	input  logic [ITER_BITS-1:0]         max_iterations,
	input  logic [LIMIT_BITS-1:0]        escape_limit,
	input  logic [STEP_BITS-1:0]         pixel_step,
	input  logic [COORD_BITS-1:0]        center_offset,
	output logic                         escaped,
	output logic [ITER_BITS-1:0]         escape_index,
	output logic [MAG_BITS-1:0]          final_magnitude_sq
);

	localparam int ZW  = 12 + FRAC_BITS;
	localparam int LW  = ZW / 2;
	localparam int HW  = ZW - LW;
	localparam int PW  = 2 * ZW;
	localparam int MSW = PW + 1;
	localparam int QW  = MSW - FRAC_BITS;
	localparam int DW  = COORD_BITS + 1;
	localparam int SW  = DW + STEP_BITS + 1;
	localparam int VW  = ZW + 2;
	localparam int XW  = (SW > VW) ? SW : VW;
	localparam int OW  = (QW > MAG_BITS) ? QW : MAG_BITS + 1;

	localparam logic signed [ZW-1:0] Z_MAX = {1'b0, {(ZW-1){1'b1}}};
	localparam logic signed [ZW-1:0] Z_MIN = {1'b1, {(ZW-1){1'b0}}};

	function automatic logic signed [ZW-1:0] sat_z(input logic signed [XW-1:0] v);
		logic [XW-ZW:0] hi;
		hi = v[XW-1:ZW-1];
		if (hi == '0 || hi == '1) return $signed(v[ZW-1:0]);
		return v[XW-1] ? Z_MIN : Z_MAX;
	endfunction

	function automatic logic [ZW-1:0] abs_z(input logic signed [ZW-1:0] v);
		logic [ZW-1:0] u;
		u = v;
		return u[ZW-1] ? (~u + 1'b1) : u;
	endfunction

	// floor(+-m / 2^F) + c, saturated
	function automatic logic signed [ZW-1:0] scale_add(
		input logic                     neg,
		input logic [MSW-1:0]           m,
		input logic signed [C_BITS-1:0] c
	);
		logic [QW-1:0] q;
		logic          rnd;
		logic [VW-1:0] qe;
		logic [VW-1:0] s;
		q   = m[MSW-1:FRAC_BITS];
		rnd = |m[FRAC_BITS-1:0];
		if (|q[QW-1:ZW]) return neg ? Z_MIN : Z_MAX;
		qe = VW'(q[ZW-1:0]);
		s  = (neg ? ~qe : qe) + VW'(c) + VW'(neg && !rnd);
		return sat_z(XW'($signed(s)));
	endfunction

	logic signed [DW-1:0]  dx, dy;
	logic signed [SW-1:0]  px, py;
	logic [ZW-1:0]         ar, ai;
	logic [MSW-1:0]        lim;
	logic [MSW-1:0]        mag_sum;
	logic [OW-1:0]         mag_q;
	logic [MAG_BITS-1:0]   mag_sat;

	logic signed [ZW-1:0]  zr_q, zi_q;
	logic [ITER_BITS-1:0]  pass_q;

	logic [ZW+LW-1:0]      rr_lo_s1, ii_lo_s1, ri_lo_s1;
	logic [ZW+HW-1:0]      rr_hi_s1, ii_hi_s1, ri_hi_s1;
	logic                  ineg_s1, ineg_s2, ineg_s3;
	logic [PW-1:0]         sr_s2, si_s2, cr_s2;
	logic                  rneg_s3;
	logic [MSW-1:0]        rm_s3, cross2_s3, mag_s3;
	logic                  gt_s3;

	assign dx = $signed({1'b0, center_offset}) - $signed({1'b0, pixel_x});
	assign dy = $signed({1'b0, center_offset}) - $signed({1'b0, pixel_y});
	assign px = SW'(dx) * SW'($signed({1'b0, pixel_step}));
	assign py = SW'(dy) * SW'($signed({1'b0, pixel_step}));

	assign ar = abs_z(zr_q);
	assign ai = abs_z(zi_q);

	assign lim     = MSW'(escape_limit) << (2 * FRAC_BITS);
	assign mag_sum = MSW'(sr_s2) + MSW'(si_s2);
	assign mag_q   = OW'(mag_s3[MSW-1:FRAC_BITS]);
	assign mag_sat = (mag_q > OW'(MAG_MAX)) ? MAG_MAX : mag_q[MAG_BITS-1:0];

	assign st.pass_zero = (pass_q == '0);
	assign st.pass_last = (pass_q == max_iterations);
	assign st.mag_gt    = gt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
		end else if (cmd.load) begin
			pass_q <= '0;
		end else if (cmd.update) begin
			pass_q <= pass_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q <= sat_z(XW'(px));
			zi_q <= sat_z(XW'(py));
		end else if (cmd.update) begin
			zr_q <= scale_add(rneg_s3, rm_s3, c_real);
			zi_q <= scale_add(ineg_s3, cross2_s3, c_imag);
		end
	end

	// partial products
	always_ff @(posedge clk) begin
		rr_lo_s1 <= (ZW+LW)'(ar) * (ZW+LW)'(ar[LW-1:0]);
		rr_hi_s1 <= (ZW+HW)'(ar) * (ZW+HW)'(ar[ZW-1:LW]);
		ii_lo_s1 <= (ZW+LW)'(ai) * (ZW+LW)'(ai[LW-1:0]);
		ii_hi_s1 <= (ZW+HW)'(ai) * (ZW+HW)'(ai[ZW-1:LW]);
		ri_lo_s1 <= (ZW+LW)'(ar) * (ZW+LW)'(ai[LW-1:0]);
		ri_hi_s1 <= (ZW+HW)'(ar) * (ZW+HW)'(ai[ZW-1:LW]);
		ineg_s1  <= zr_q[ZW-1] ^ zi_q[ZW-1];
	end

	// full products
	always_ff @(posedge clk) begin
		sr_s2   <= (PW'(rr_hi_s1) << LW) + PW'(rr_lo_s1);
		si_s2   <= (PW'(ii_hi_s1) << LW) + PW'(ii_lo_s1);
		cr_s2   <= (PW'(ri_hi_s1) << LW) + PW'(ri_lo_s1);
		ineg_s2 <= ineg_s1;
	end

	// difference, doubled cross term, magnitude test
	always_ff @(posedge clk) begin
		rneg_s3   <= si_s2 > sr_s2;
		rm_s3     <= (si_s2 > sr_s2) ? MSW'(si_s2 - sr_s2) : MSW'(sr_s2 - si_s2);
		cross2_s3 <= {cr_s2, 1'b0};
		mag_s3    <= mag_sum;
		gt_s3     <= mag_sum > lim;
		ineg_s3   <= ineg_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			escaped            <= cmd.out_esc;
			escape_index       <= cmd.out_esc ? pass_q - 1'b1 : '0;
			final_magnitude_sq <= cmd.out_esc ? mag_sat : '0;
		end
	end

endmodule

// ----- design/julia_escape_time.sv -----
// ----------------------------------------------------------------------------
// julia_escape_time
// Escape-time iteration z = z*z + c for one pixel, fixed point.
// Each pass over z runs through the squarer/cross pipeline and then the z update.
// One pixel at a time; the next is taken the cycle after the result is registered.
// Reset returns the sequencer to idle, drops out_valid, restores the config registers.
// ----------------------------------------------------------------------------
module julia_escape_time import jet_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [COORD_BITS-1:0]    pixel_x,
	input  logic [COORD_BITS-1:0]    pixel_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     escaped,
	output logic [ITER_BITS-1:0]     escape_index,
	output logic [MAG_BITS-1:0]      final_magnitude_sq
);

	logic signed [C_BITS-1:0] c_real, c_imag;
	logic [ITER_BITS-1:0]     max_iterations;
	logic [LIMIT_BITS-1:0]    escape_limit;
	logic [STEP_BITS-1:0]     pixel_step;
	logic [COORD_BITS-1:0]    center_offset;
	jet_cmd_t                 cmd;
	jet_status_t              st;

	jet_regs #(
		.COORD_BITS(COORD_BITS)
	) u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.c_real         (c_real),
		.c_imag         (c_imag),
		.max_iterations (max_iterations),
		.escape_limit   (escape_limit),
		.pixel_step     (pixel_step),
		.center_offset  (center_offset)
	);

	jet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	jet_datapath #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.st                 (st),
		.pixel_x            (pixel_x),
		.pixel_y            (pixel_y),
		.c_real             (c_real),
		.c_imag             (c_imag),
		.max_iterations     (max_iterations),
		.escape_limit       (escape_limit),
		.pixel_step         (pixel_step),
		.center_offset      (center_offset),
		.escaped            (escaped),
		.escape_index       (escape_index),
		.final_magnitude_sq (final_magnitude_sq)
	);

	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second pixel taken while one is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register overwritten before transfer");

	a_iter_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !st.pass_last)
		else $error("iteration past the limit");

	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !escaped |-> escape_index == '0 && final_magnitude_sq == '0)
		else $error("bounded pixel reports nonzero index or magnitude");

endmodule
